[sv/sliding_window_anagram_search_macros.svh]
// Assertion macros for the anagram search block.
// Expects signals named clk and rst_n in the scope where they are used.
`ifndef SLIDING_WINDOW_ANAGRAM_SEARCH_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/swas_pkg.sv]
// Shared types and fixed constants for the anagram search block.
// No dependencies.
package swas_pkg;

  localparam int SWAS_SYM_W     = 5;
  localparam int SWAS_LETTER_W  = 7;
  localparam int SWAS_QUEUE_DEPTH = 4;
  localparam int SWAS_OUT_DEPTH   = 4;

  typedef enum logic {
    SWAS_OP_PATTERN = 1'b0,
    SWAS_OP_TEXT    = 1'b1
  } swas_op_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                  is_text;
    logic                  clear;
    logic [SWAS_SYM_W-1:0] symbol;
    logic                  count_en;
    logic                  evict;
    logic [SWAS_SYM_W-1:0] old_symbol;
    logic                  full;
    logic                  overflow;
  } swas_item_t;

  typedef struct packed {
    logic window_full;
    logic window_match;
    logic found;
    logic pattern_overflow;
  } swas_result_t;

  localparam int SWAS_ITEM_W   = $bits(swas_item_t);
  localparam int SWAS_RESULT_W = $bits(swas_result_t);

endpackage

[sv/swas_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
module swas_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/swas_fifo.sv]
// Small register FIFO with fall-through read and a fill level output.
// No dependencies.
module swas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full,
  output logic [LW-1:0]    level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             do_push, do_pop;

  assign empty    = (level_r == '0);
  assign full     = (level_r == LW'(DEPTH));
  assign level    = level_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/swas_front.sv]
// Front end: accepts words, tracks pattern length, window fill and ring pointer,
// drives the symbol ring. Depends on swas_pkg and swas_ram.
module swas_front
  import swas_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int ALPHABET    = 26,
  localparam int QLW = $clog2(SWAS_QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation,
  input  logic [SWAS_SYM_W-1:0] symbol,
  input  logic                  starts_query,
  input  logic [QLW-1:0]        q_level,
  output logic                  q_push,
  output swas_item_t            q_item
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [LW-1:0]         plen_r, plen_nxt, plen_c;
  logic [LW-1:0]         tseen_r, tseen_nxt, tseen_c;
  logic [AW-1:0]         ptr_r, ptr_nxt, ptr_c;
  logic                  ovf_r, ovf_nxt, ovf_c;
  logic                  f1_valid_r;
  swas_item_t            f1_r, item_nxt;
  logic                  accept, is_text, sym_ok, room, active, evict;
  logic                  ring_we;
  logic [LW:0]           ptr_ext, plen_ext, old_ext;
  logic [AW-1:0]         old_idx;
  logic [SWAS_SYM_W-1:0] ram_rdata;
  logic [QLW:0]          fill;

  // reserve a slot for the word already waiting on ring read data
  assign fill   = {1'b0, q_level} + (QLW + 1)'(f1_valid_r);
  assign full   = (fill >= (QLW + 1)'(SWAS_QUEUE_DEPTH));
  assign accept = push && !full;

  assign is_text = (operation == SWAS_OP_TEXT);
  assign sym_ok  = (SWAS_LETTER_W'(symbol) < SWAS_LETTER_W'(ALPHABET));

  always_comb begin
    plen_c  = starts_query ? '0 : plen_r;
    tseen_c = starts_query ? '0 : tseen_r;
    ptr_c   = starts_query ? '0 : ptr_r;
    ovf_c   = starts_query ? 1'b0 : ovf_r;

    room   = (plen_c != LW'(MAX_PATTERN));
    active = (plen_c != '0);
    evict  = active && (tseen_c >= plen_c);

    // oldest ring slot = pointer minus pattern length, modulo ring size
    ptr_ext  = (LW + 1)'(ptr_c);
    plen_ext = {1'b0, plen_c};
    if (ptr_ext >= plen_ext) begin
      old_ext = ptr_ext - plen_ext;
    end else begin
      old_ext = ptr_ext + (LW + 1)'(MAX_PATTERN) - plen_ext;
    end
    old_idx = old_ext[AW-1:0];

    plen_nxt  = plen_c;
    tseen_nxt = tseen_c;
    ptr_nxt   = ptr_c;
    ovf_nxt   = ovf_c;
    ring_we   = 1'b0;

    item_nxt            = '0;
    item_nxt.is_text    = is_text;
    item_nxt.clear      = starts_query;
    item_nxt.symbol     = symbol;

    if (!is_text) begin
      if (!room) begin
        ovf_nxt = 1'b1;
      end else if (sym_ok) begin
        plen_nxt          = plen_c + 1'b1;
        item_nxt.count_en = 1'b1;
      end
    end else begin
      if (active) begin
        ring_we           = accept;
        item_nxt.count_en = sym_ok;
        item_nxt.evict    = evict;
        if (!evict) begin
          tseen_nxt = tseen_c + 1'b1;
        end
        ptr_nxt = (ptr_c == AW'(MAX_PATTERN - 1)) ? '0 : ptr_c + 1'b1;
      end
    end

    item_nxt.full     = (tseen_nxt >= plen_c);
    item_nxt.overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= '0;
      tseen_r    <= '0;
      ptr_r      <= '0;
      ovf_r      <= 1'b0;
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
      if (accept) begin
        plen_r  <= plen_nxt;
        tseen_r <= tseen_nxt;
        ptr_r   <= ptr_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_r <= item_nxt;
    end
  end

  swas_ram #(
    .WIDTH (SWAS_SYM_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_c),
    .wdata (symbol),
    .raddr (old_idx),
    .rdata (ram_rdata)
  );

  // ring read data lands in the cycle after the word was taken
  always_comb begin
    q_item            = f1_r;
    q_item.old_symbol = ram_rdata;
  end
  assign q_push = f1_valid_r;

endmodule

[sv/swas_back.sv]
// Back end: per-letter pattern and window counters, window compare, sticky found.
// Depends on swas_pkg.
module swas_back
  import swas_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int ALPHABET    = 26,
  localparam int OLW = $clog2(SWAS_OUT_DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  swas_item_t   q_item,
  output logic         q_pop,
  input  logic [OLW-1:0] o_level,
  output logic         o_push,
  output swas_result_t o_result
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [CW-1:0] pcnt_r [ALPHABET];
  logic [CW-1:0] pcnt_nxt [ALPHABET];
  logic [CW-1:0] wcnt_r [ALPHABET];
  logic [CW-1:0] wcnt_nxt [ALPHABET];
  logic          b2_valid_r;
  swas_item_t    b2_r;
  logic          found_r, found_upd;
  logic          counts_eq, match;
  logic [OLW:0]  o_fill;

  assign o_fill = {1'b0, o_level} + (OLW + 1)'(b2_valid_r && b2_r.is_text);
  assign q_pop  = !q_empty && (o_fill < (OLW + 1)'(SWAS_OUT_DEPTH));

  // one lane per letter
  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      logic [CW-1:0] pb, wb;
      logic          inc_p, inc_w, dec_w;
      pb    = q_item.clear ? '0 : pcnt_r[i];
      wb    = q_item.clear ? '0 : wcnt_r[i];
      inc_p = !q_item.is_text && q_item.count_en &&
              (SWAS_LETTER_W'(q_item.symbol) == SWAS_LETTER_W'(i));
      inc_w = q_item.is_text && q_item.count_en &&
              (SWAS_LETTER_W'(q_item.symbol) == SWAS_LETTER_W'(i));
      dec_w = q_item.is_text && q_item.evict && (wb != '0) &&
              (SWAS_LETTER_W'(q_item.old_symbol) == SWAS_LETTER_W'(i));
      if (q_pop) begin
        pcnt_nxt[i] = pb + CW'(inc_p);
        wcnt_nxt[i] = wb + CW'(inc_w) - CW'(dec_w);
      end else begin
        pcnt_nxt[i] = pcnt_r[i];
        wcnt_nxt[i] = wcnt_r[i];
      end
    end
  end

  always_comb begin
    counts_eq = 1'b1;
    for (int i = 0; i < ALPHABET; i++) begin
      counts_eq = counts_eq && (pcnt_r[i] == wcnt_r[i]);
    end
    match     = b2_r.is_text && b2_r.full && counts_eq;
    found_upd = (b2_r.clear ? 1'b0 : found_r) | match;

    o_result.window_full      = b2_r.full;
    o_result.window_match     = match;
    o_result.found            = found_upd;
    o_result.pattern_overflow = b2_r.overflow;
  end

  assign o_push = b2_valid_r && b2_r.is_text;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        pcnt_r[i] <= '0;
        wcnt_r[i] <= '0;
      end
      b2_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      pcnt_r     <= pcnt_nxt;
      wcnt_r     <= wcnt_nxt;
      b2_valid_r <= q_pop;
      if (b2_valid_r) begin
        found_r <= found_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_r <= q_item;
    end
  end

endmodule

[sv/sliding_window_anagram_search.sv]
// Sliding-window anagram search, top level; depends on swas_pkg, swas_front,
// swas_fifo, swas_back and the assertion macro header. A query streams pattern
// words (operation 0) and then text words (operation 1), symbols 0..ALPHABET-1;
// starts_query on a word clears everything before that word is applied. Each
// text word yields one result word: window_full, window_match (the last
// pattern-length text symbols are a permutation of the pattern), a sticky
// found flag and pattern_overflow (pattern symbols beyond MAX_PATTERN were
// dropped); pattern words yield nothing. An empty pattern matches every text
// word. Rate: one word per clock while results are popped, from the update of
// all per-letter counters at once and the one-read, one-write ring RAM port
// pair. A word passes a ring-read stage in the front, the internal queue, a
// counter-update stage and a compare stage in the back, then the result
// queue before the out_ ports. Both sides are queue-like: full stays low while
// the internal four-word queue has room, so input is taken while results wait.
module sliding_window_anagram_search
  import swas_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int ALPHABET    = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_operation,
  input  logic [SWAS_SYM_W-1:0] in_symbol,
  input  logic                  in_starts_query,
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_window_full,
  output logic                  out_window_match,
  output logic                  out_found,
  output logic                  out_pattern_overflow
);

  localparam int QLW = $clog2(SWAS_QUEUE_DEPTH + 1);
  localparam int OLW = $clog2(SWAS_OUT_DEPTH + 1);

  // front -> queue
  logic                     q_push;
  swas_item_t               q_in_item;
  logic [SWAS_ITEM_W-1:0]   q_in_bits;
  // queue -> back
  logic [SWAS_ITEM_W-1:0]   q_out_bits;
  swas_item_t               q_out_item;
  logic                     q_pop, q_empty, q_full;
  logic [QLW-1:0]           q_level;
  // back -> result queue
  logic                     o_push, o_full;
  swas_result_t             o_in_result, o_out_result;
  logic [SWAS_RESULT_W-1:0] o_out_bits;
  logic [OLW-1:0]           o_level;

  // Front: classifies each word, keeps lengths and ring pointer, owns the ring.
  swas_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .operation    (in_operation),
    .symbol       (in_symbol),
    .starts_query (in_starts_query),
    .q_level      (q_level),
    .q_push       (q_push),
    .q_item       (q_in_item)
  );

  assign q_in_bits = q_in_item;

  // Decoupling queue between front and back.
  swas_fifo #(
    .WIDTH (SWAS_ITEM_W),
    .DEPTH (SWAS_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_bits),
    .pop       (q_pop),
    .pop_data  (q_out_bits),
    .empty     (q_empty),
    .full      (q_full),
    .level     (q_level)
  );

  assign q_out_item = q_out_bits;

  // Back: letter counters, window compare, sticky found.
  swas_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_out_item),
    .q_pop    (q_pop),
    .o_level  (o_level),
    .o_push   (o_push),
    .o_result (o_in_result)
  );

  // Result queue; the back end only issues when a slot is sure to be free.
  swas_fifo #(
    .WIDTH (SWAS_RESULT_W),
    .DEPTH (SWAS_OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (o_push),
    .push_data (o_in_result),
    .pop       (pop),
    .pop_data  (o_out_bits),
    .empty     (empty),
    .full      (o_full),
    .level     (o_level)
  );

  assign o_out_result         = o_out_bits;
  assign out_window_full      = o_out_result.window_full;
  assign out_window_match     = o_out_result.window_match;
  assign out_found            = o_out_result.found;
  assign out_pattern_overflow = o_out_result.pattern_overflow;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "sliding_window_anagram_search_macros.svh"

  // front credit scheme must never overrun the internal queue
  `SWAS_ASSERT_NOW(a_queue_no_overrun, q_push, !q_full, "front pushed into a full queue")
  // back issue control must never overrun the result queue
  `SWAS_ASSERT_NOW(a_out_no_overrun, o_push, !o_full, "back pushed into a full result queue")
  // a match needs a full window and always raises found
  `SWAS_ASSERT_NOW(a_match_full, o_push && o_in_result.window_match, o_in_result.window_full && o_in_result.found, "match without full window or found")
  // a taken word always leaves the front on the next cycle
  `SWAS_ASSERT_NEXT(a_front_forward, push && !full, q_push, "accepted word not forwarded")

endmodule

[tb/sliding_window_anagram_search_tb.sv]
// Self-checking testbench for sliding_window_anagram_search: directed words, then random queries.
// Depends on swas_pkg and the block itself. Results are checked against a local window predictor.
`timescale 1ns / 1ps

module sliding_window_anagram_search_tb;
  import swas_pkg::*;

  localparam int MAX_PAT        = 32;
  localparam int N_LETTERS      = 26;
  localparam int RESULT_LATENCY = 3;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int WORDS_PER_PHASE = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic                  in_operation;
  logic [SWAS_SYM_W-1:0] in_symbol;
  logic                  in_starts_query;
  logic                  empty;
  logic                  pop;
  logic                  out_window_full;
  logic                  out_window_match;
  logic                  out_found;
  logic                  out_pattern_overflow;

  sliding_window_anagram_search #(
    .MAX_PATTERN(MAX_PAT),
    .ALPHABET   (N_LETTERS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_operation        (in_operation),
    .in_symbol           (in_symbol),
    .in_starts_query     (in_starts_query),
    .empty               (empty),
    .pop                 (pop),
    .out_window_full     (out_window_full),
    .out_window_match    (out_window_match),
    .out_found           (out_found),
    .out_pattern_overflow(out_pattern_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idling knobs, percent of cycles
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned cycles       = 0;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned matches_seen = 0;
  int unsigned overflows_seen = 0;
  int unsigned mismatches   = 0;

  // Expected verdicts, oldest first
  swas_result_t window_verdicts[$];

  // ---------------------------------------------------------------------------
  // Window predictor: letter histograms of pattern and text window, plus the
  // ring of recent text symbols used to find the one that drops out.
  // ---------------------------------------------------------------------------
  logic [5:0]            pat_cnt   [N_LETTERS];
  logic [5:0]            win_cnt   [N_LETTERS];
  logic [SWAS_SYM_W-1:0] ring_syms [MAX_PAT];
  int unsigned           pat_len;
  int unsigned           text_seen;
  int unsigned           ring_ptr;
  bit                    found_sticky;
  bit                    ovf_sticky;

  function automatic void clear_query();
    for (int i = 0; i < N_LETTERS; i++) begin
      pat_cnt[i] = '0;
      win_cnt[i] = '0;
    end
    pat_len      = 0;
    text_seen    = 0;
    ring_ptr     = 0;
    found_sticky = 1'b0;
    ovf_sticky   = 1'b0;
  endfunction

  // Returns 1 when the word yields a result (text words only)
  function automatic bit predict_window(input swas_op_t op, input logic [SWAS_SYM_W-1:0] sym,
                                        input logic sq, output swas_result_t res);
    int unsigned           old_idx;
    logic [SWAS_SYM_W-1:0] old_sym;
    bit                    same;
    res = '0;
    if (sq) clear_query();
    if (op == SWAS_OP_PATTERN) begin
      // full pattern: word dropped, flag set; foreign letters ignored
      if (pat_len >= MAX_PAT) ovf_sticky = 1'b1;
      else if (sym < N_LETTERS) begin
        pat_cnt[sym] = pat_cnt[sym] + 6'd1;
        pat_len      = pat_len + 1;
      end
      return 1'b0;
    end
    // empty pattern: window never moves, compares all-zero histograms
    if (pat_len > 0) begin
      if (text_seen >= pat_len) begin
        old_idx = (ring_ptr + MAX_PAT - pat_len) % MAX_PAT;
        old_sym = ring_syms[old_idx];
        if (old_sym < N_LETTERS && win_cnt[old_sym] > 0)
          win_cnt[old_sym] = win_cnt[old_sym] - 6'd1;
      end else begin
        text_seen = text_seen + 1;
      end
      ring_syms[ring_ptr] = sym;
      if (sym < N_LETTERS) win_cnt[sym] = win_cnt[sym] + 6'd1;
      ring_ptr = (ring_ptr + 1) % MAX_PAT;
    end
    same = 1'b1;
    for (int i = 0; i < N_LETTERS; i++)
      if (pat_cnt[i] != win_cnt[i]) same = 1'b0;
    res.window_full      = (text_seen >= pat_len);
    res.window_match     = res.window_full && same;
    if (res.window_match) found_sticky = 1'b1;
    res.found            = found_sticky;
    res.pattern_overflow = ovf_sticky;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drive on the falling edge, word taken at the rising edge with
  // push high and full low. Push is left high; the next call re-drives it.
  // ---------------------------------------------------------------------------
  task automatic send_word(input swas_op_t op, input logic [SWAS_SYM_W-1:0] sym,
                           input logic sq);
    swas_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    in_operation    <= op;
    in_symbol       <= sym;
    in_starts_query <= sq;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_window(op, sym, sq, res)) window_verdicts.push_back(res);
    words_sent++;
  endtask

  // Sender goes quiet until every expected verdict is back
  task automatic wait_for_results();
    @(negedge clk);
    push <= 1'b0;
    while (window_verdicts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Receiver stalls at random
  always @(negedge clk) pop <= ($urandom_range(99) >= stall_pct);

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic exp_v, input logic act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0b got %0b (result %0d)",
               $realtime, what, exp_v, act_v, results_seen);
  endtask

  always @(posedge clk) begin
    swas_result_t exp_r;
    if (rst_n && pop && !empty) begin
      if (window_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word with nothing expected", $realtime);
      end else begin
        exp_r = window_verdicts.pop_front();
        if (exp_r.window_full !== out_window_full)
          note_mismatch("window_full", exp_r.window_full, out_window_full);
        if (exp_r.window_match !== out_window_match)
          note_mismatch("window_match", exp_r.window_match, out_window_match);
        if (exp_r.found !== out_found)
          note_mismatch("found", exp_r.found, out_found);
        if (exp_r.pattern_overflow !== out_pattern_overflow)
          note_mismatch("pattern_overflow", exp_r.pattern_overflow, out_pattern_overflow);
        if (exp_r.window_match) matches_seen++;
        if (exp_r.pattern_overflow) overflows_seen++;
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // query opened by a text word: no pattern, so every window matches
  task automatic test_empty_pattern();
    send_word(SWAS_OP_TEXT, 5'd0, 1'b1);
    send_word(SWAS_OP_TEXT, 5'd25, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd31, 1'b0);
  endtask

  task automatic test_letter_extremes();
    send_word(SWAS_OP_PATTERN, 5'd0, 1'b1);
    send_word(SWAS_OP_PATTERN, 5'd25, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd25, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd0, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd31, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd25, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd0, 1'b0);
  endtask

  // foreign pattern letters vanish; foreign text letters occupy a slot
  task automatic test_foreign_symbols();
    send_word(SWAS_OP_PATTERN, 5'd3, 1'b1);
    send_word(SWAS_OP_PATTERN, 5'd26, 1'b0);
    send_word(SWAS_OP_PATTERN, 5'd31, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd31, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd3, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd30, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd3, 1'b0);
  endtask

  // pattern grows mid-text, window must grow with it
  task automatic test_pattern_after_text();
    send_word(SWAS_OP_PATTERN, 5'd1, 1'b1);
    send_word(SWAS_OP_TEXT, 5'd2, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd1, 1'b0);
    send_word(SWAS_OP_PATTERN, 5'd2, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd7, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd2, 1'b0);
    send_word(SWAS_OP_TEXT, 5'd1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random queries
  // ---------------------------------------------------------------------------
  // Pattern of plen letters, mostly a narrow band (so anagrams turn up), then text
  // with planted shuffles; optionally the pattern is extended part way through.
  task automatic send_anagram_query(input int plen, input bit late_pattern);
    logic [SWAS_SYM_W-1:0] pat_q[$];
    logic [SWAS_SYM_W-1:0] shuf[$];
    logic [SWAS_SYM_W-1:0] sym;
    int                    band;
    int                    base;
    int                    tlen;
    int                    k;
    bit                    opening;
    band    = ($urandom_range(3) == 0) ? $urandom_range(2, 26) : $urandom_range(1, 4);
    base    = $urandom_range(0, 26 - band);
    opening = 1'b1;
    for (int i = 0; i < plen; i++) begin
      sym = SWAS_SYM_W'(base + $urandom_range(band - 1));
      pat_q.push_back(sym);
      send_word(SWAS_OP_PATTERN, sym, opening);
      opening = 1'b0;
    end
    tlen = $urandom_range(0, 2 * plen + 6);
    for (int t = 0; t < tlen; t++) begin
      if (late_pattern && t == tlen / 2) begin
        repeat ($urandom_range(1, 3)) begin
          sym = SWAS_SYM_W'(base + $urandom_range(band - 1));
          pat_q.push_back(sym);
          send_word(SWAS_OP_PATTERN, sym, 1'b0);
        end
      end
      if ($urandom_range(4) == 0 && pat_q.size() != 0) begin
        shuf = pat_q;
        while (shuf.size() != 0) begin
          k = $urandom_range(shuf.size() - 1);
          send_word(SWAS_OP_TEXT, shuf[k], opening);
          opening = 1'b0;
          shuf.delete(k);
        end
      end else begin
        sym = ($urandom_range(19) == 0) ? SWAS_SYM_W'($urandom_range(26, 31))
                                        : SWAS_SYM_W'(base + $urandom_range(band - 1));
        send_word(SWAS_OP_TEXT, sym, opening);
        opening = 1'b0;
      end
    end
  endtask

  task automatic test_pattern_overflow();
    send_anagram_query(MAX_PAT + $urandom_range(1, 4), 1'b0);
  endtask

  task automatic run_query_mix(input int unsigned n_words);
    int unsigned first;
    int unsigned pick;
    first = words_sent;
    while (words_sent - first < n_words) begin
      pick = $urandom_range(99);
      if (pick < 60)      send_anagram_query($urandom_range(1, 6), 1'b0);
      else if (pick < 68) send_anagram_query($urandom_range(7, MAX_PAT), 1'b0);
      else if (pick < 73) send_anagram_query(MAX_PAT + $urandom_range(1, 4), 1'b0);
      else if (pick < 80) send_anagram_query($urandom_range(1, 5), 1'b1);
      else if (pick < 83) send_anagram_query(0, 1'b0);
      else begin
        // noise: any op, any symbol, occasional restart
        repeat ($urandom_range(1, 8))
          send_word(swas_op_t'($urandom_range(1)), SWAS_SYM_W'($urandom_range(31)),
                    ($urandom_range(9) == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    push            = 1'b0;
    in_operation    = 1'b0;
    in_symbol       = '0;
    in_starts_query = 1'b0;
    clear_query();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no idling on either side
    test_empty_pattern();
    test_letter_extremes();
    test_foreign_symbols();
    test_pattern_after_text();
    test_pattern_overflow();
    run_query_mix(WORDS_PER_PHASE);
    wait_for_results();

    idle_pct  = 72;
    stall_pct = 0;
    run_query_mix(WORDS_PER_PHASE);
    wait_for_results();

    idle_pct  = 0;
    stall_pct = 72;
    run_query_mix(WORDS_PER_PHASE);
    wait_for_results();

    idle_pct  = 7;
    stall_pct = 7;
    run_query_mix(WORDS_PER_PHASE);
    wait_for_results();

    $display("Sent %0d words, checked %0d result words in %0d cycles.",
             words_sent, results_seen, cycles);
    $display("Windows matching: %0d, results with pattern overflow: %0d, mismatches: %0d.",
             matches_seen, overflows_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
